/* hdl/assert_macros.svh */
// -----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the quantizer checkers.
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle property");

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle property");

`endif

/* hdl/pndq_pkg.sv */
// -----------------------------------------------------------------------------
// pndq_pkg
// Types and constants shared by the peak normalizing quantizer modules.
// -----------------------------------------------------------------------------
package pndq_pkg;

   localparam int SAMPLE_W    = 24;
   localparam int PEAK_W      = 23;
   localparam int SCALE_W     = 48;
   localparam int ALPHA_W     = 23;
   localparam int CODE_W      = 12;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = 2;
   localparam int QUEUE_CW    = 3;
   localparam int DIV_STEPS   = 48;
   localparam int DIV_CW      = 6;

   localparam logic [ALPHA_W-1:0] ALPHA_AUDIO    = 23'd429497;
   localparam logic [ALPHA_W-1:0] ALPHA_SPECTRUM = 23'd4294967;
   localparam logic [CODE_W-1:0]  CODE_MAX       = 12'hfff;
   localparam logic [CODE_W-1:0]  CODE_ZERO      = 12'd0;
   localparam logic [CODE_W-1:0]  CODE_FIRST     = 12'd1;
   localparam logic [SCALE_W-1:0] ONE_Q47        = 48'h8000_0000_0000;

   localparam logic MODE_AUDIO    = 1'b0;
   localparam logic MODE_SPECTRUM = 1'b1;

   localparam logic CMD_PUSH = 1'b0;
   localparam logic CMD_READ = 1'b1;

   typedef enum logic [1:0] {
      OP_PUSH,
      OP_PUSH_CLOSE,
      OP_READ
   } op_type;

   typedef struct packed {
      op_type                      op;
      logic signed [SAMPLE_W-1:0]  sample;
      logic                        mode;
   } item_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DIV_START,
      S_DIV_WAIT,
      S_ALPHA_HI,
      S_ALPHA_LO,
      S_ALPHA_SUM,
      S_SCALE_ADD,
      S_RD_MEM,
      S_RD_MUL_LO,
      S_RD_SUM,
      S_RD_LEVEL,
      S_RD_OUT
   } back_state_type;

endpackage

/* hdl/pndq_front.sv */
// -----------------------------------------------------------------------------
// pndq_front
// Accepts transactions, decodes them into operations and queues them.
// -----------------------------------------------------------------------------
module pndq_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic                        req_cmd,
   input  logic signed [23:0]          req_sample,
   input  logic                        req_frame_end,
   input  logic                        csr_wr_en,
   input  logic                        csr_wr_data,
   input  logic                        pop,
   output pndq_pkg::item_type          head,
   output logic                        empty
);
   import pndq_pkg::*;

   item_type               queue_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CW-1:0]    count_ff, count_in;
   logic                   mode_ff, mode_in;
   logic                   accept;
   logic                   do_pop;
   item_type               new_item;

   assign busy   = (count_ff == QUEUE_CW'(QUEUE_DEPTH));
   assign empty  = (count_ff == '0);
   assign accept = start && !busy;
   assign do_pop = pop && !empty;
   assign head   = queue_ff[rd_ptr_ff];

   always_comb begin
      new_item.sample = req_sample;
      new_item.mode   = mode_ff;
      if (req_cmd == CMD_READ) begin
         new_item.op = OP_READ;
      end else if (req_frame_end) begin
         new_item.op = OP_PUSH_CLOSE;
      end else begin
         new_item.op = OP_PUSH;
      end

      wr_ptr_in = accept ? wr_ptr_ff + QUEUE_AW'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + QUEUE_AW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (accept && !do_pop) begin
         count_in = count_ff + QUEUE_CW'(1);
      end else if (!accept && do_pop) begin
         count_in = count_ff - QUEUE_CW'(1);
      end
      mode_in = csr_wr_en ? csr_wr_data : mode_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
         mode_ff   <= MODE_AUDIO;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
         mode_ff   <= mode_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         queue_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

/* hdl/pndq_div.sv */
// -----------------------------------------------------------------------------
// pndq_div
// Bit-serial restoring divider computing floor(2^47 / divisor).
// -----------------------------------------------------------------------------
module pndq_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        go,
   input  logic [pndq_pkg::PEAK_W-1:0] divisor,
   output logic                        done,
   output logic [pndq_pkg::SCALE_W-1:0] quotient
);
   import pndq_pkg::*;

   logic [PEAK_W-1:0]   rem_ff, rem_in;
   logic [SCALE_W-1:0]  quot_ff, quot_in;
   logic [PEAK_W-1:0]   dvs_ff, dvs_in;
   logic [DIV_CW-1:0]   cnt_ff, cnt_in;
   logic                active_ff, active_in;
   logic                done_ff, done_in;
   logic [PEAK_W:0]     trial;
   logic                fits;

   assign done     = done_ff;
   assign quotient = quot_ff;

   always_comb begin
      // dividend is 2^47: only the first bit shifted in is one
      trial     = {rem_ff, (cnt_ff == DIV_CW'(DIV_STEPS))};
      fits      = (trial >= {1'b0, dvs_ff});
      rem_in    = rem_ff;
      quot_in   = quot_ff;
      dvs_in    = dvs_ff;
      cnt_in    = cnt_ff;
      active_in = active_ff;
      done_in   = 1'b0;
      if (go) begin
         rem_in    = '0;
         quot_in   = '0;
         dvs_in    = divisor;
         cnt_in    = DIV_CW'(DIV_STEPS);
         active_in = 1'b1;
      end else if (active_ff) begin
         rem_in  = fits ? PEAK_W'(trial - {1'b0, dvs_ff}) : trial[PEAK_W-1:0];
         quot_in = {quot_ff[SCALE_W-2:0], fits};
         cnt_in  = cnt_ff - DIV_CW'(1);
         if (cnt_ff == DIV_CW'(1)) begin
            active_in = 1'b0;
            done_in   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
         cnt_ff    <= '0;
      end else begin
         active_ff <= active_in;
         done_ff   <= done_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
      dvs_ff  <= dvs_in;
   end

endmodule

/* hdl/pndq_back.sv */
// -----------------------------------------------------------------------------
// pndq_back
// Executes queued operations: frame store, peak, scale update, quantizing.
// -----------------------------------------------------------------------------
module pndq_back #(
   parameter int FRAME_DEPTH = 1024
) (
   input  logic                          clock,
   input  logic                          reset,
   input  pndq_pkg::item_type            head,
   input  logic                          empty,
   output logic                          pop,
   output logic                          rsp_strobe,
   output logic [pndq_pkg::CODE_W-1:0]   rsp_code,
   output logic                          rsp_last_code
);
   import pndq_pkg::*;

   localparam int AW = (FRAME_DEPTH > 1) ? $clog2(FRAME_DEPTH) : 1;
   localparam int CW = $clog2(FRAME_DEPTH + 1);

   back_state_type       state_ff, state_in;
   logic [CW-1:0]        len_ff, len_in;
   logic [CW-1:0]        pos_ff, pos_in;
   logic [PEAK_W-1:0]    peak_ff, peak_in;
   logic [SCALE_W-1:0]   scale_ff, scale_in;
   logic                 closed_ff, closed_in;
   logic                 strobe_ff, strobe_in;

   logic [SCALE_W-1:0]   diff_ff, diff_in;
   logic [ALPHA_W-1:0]   alpha_ff, alpha_in;
   logic [SCALE_W-1:0]   hi_ff, hi_in;
   logic [SCALE_W-1:0]   prod_ff;
   logic [39:0]          step_ff, step_in;
   logic [SAMPLE_W-1:0]  m_ff, m_in;
   logic                 neg_ff, neg_in;
   logic                 first_ff, first_in;
   logic                 last_ff, last_in;
   logic                 mode_ff, mode_in;
   logic                 big_ff, big_in;
   logic [SCALE_W:0]     p_ff, p_in;
   logic [SCALE_W-1:0]   v_ff, v_in;
   logic                 sat_zero_ff, sat_zero_in;
   logic                 sat_full_ff, sat_full_in;
   logic [CODE_W-1:0]    code_ff, code_in;
   logic                 rlast_ff, rlast_in;

   logic [SAMPLE_W-1:0]  frame_mem [FRAME_DEPTH];
   logic [SAMPLE_W-1:0]  rdata_ff;
   logic                 mem_we;
   logic [AW-1:0]        mem_waddr;
   logic [AW-1:0]        mem_raddr;

   logic [SAMPLE_W-1:0]  mul_a, mul_b;
   logic                 div_go, div_done;
   logic [SCALE_W-1:0]   div_q;

   logic [CW-1:0]        len_base;
   logic [71:0]          sum72;
   logic [SAMPLE_W-1:0]  m_now;
   logic                 p_ge_one;
   logic [59:0]          t60;

   pndq_div u_div (
      .clock    (clock),
      .reset    (reset),
      .go       (div_go),
      .divisor  (peak_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   assign rsp_strobe    = strobe_ff;
   assign rsp_code      = code_ff;
   assign rsp_last_code = rlast_ff;

   always_comb begin
      state_in    = state_ff;
      len_in      = len_ff;
      pos_in      = pos_ff;
      peak_in     = peak_ff;
      scale_in    = scale_ff;
      closed_in   = closed_ff;
      strobe_in   = 1'b0;
      diff_in     = diff_ff;
      alpha_in    = alpha_ff;
      hi_in       = hi_ff;
      step_in     = step_ff;
      m_in        = m_ff;
      neg_in      = neg_ff;
      first_in    = first_ff;
      last_in     = last_ff;
      mode_in     = mode_ff;
      big_in      = big_ff;
      p_in        = p_ff;
      v_in        = v_ff;
      sat_zero_in = sat_zero_ff;
      sat_full_in = sat_full_ff;
      code_in     = code_ff;
      rlast_in    = rlast_ff;
      pop         = 1'b0;
      mem_we      = 1'b0;
      mem_waddr   = len_ff[AW-1:0];
      mem_raddr   = pos_ff[AW-1:0];
      mul_a       = '0;
      mul_b       = '0;
      div_go      = 1'b0;
      len_base    = closed_ff ? '0 : len_ff;
      sum72       = {hi_ff, 24'd0} + {24'd0, prod_ff};
      m_now       = rdata_ff[SAMPLE_W-1] ? SAMPLE_W'(~rdata_ff + SAMPLE_W'(1)) : rdata_ff;
      p_ge_one    = p_ff[SCALE_W] || p_ff[SCALE_W-1];
      t60         = {v_ff, 12'd0} - {12'd0, v_ff};

      case (state_ff)
         S_IDLE: begin
            if (!empty) begin
               pop = 1'b1;
               case (head.op)
                  OP_PUSH, OP_PUSH_CLOSE: begin
                     // a push after a closed frame opens a new one
                     if (closed_ff) begin
                        pos_in    = '0;
                        peak_in   = '0;
                        closed_in = 1'b0;
                     end
                     mem_waddr = len_base[AW-1:0];
                     if (len_base < CW'(FRAME_DEPTH)) begin
                        mem_we = 1'b1;
                        len_in = len_base + CW'(1);
                        if (len_base != '0 && !head.sample[SAMPLE_W-1]
                            && head.sample[PEAK_W-1:0] > (closed_ff ? '0 : peak_ff)) begin
                           peak_in = head.sample[PEAK_W-1:0];
                        end
                     end else begin
                        len_in = len_base;
                     end
                     if (head.op == OP_PUSH_CLOSE) begin
                        closed_in = 1'b1;
                        alpha_in  = (head.mode == MODE_SPECTRUM) ? ALPHA_SPECTRUM
                                                                 : ALPHA_AUDIO;
                        state_in  = S_DIV_START;
                     end
                  end
                  OP_READ: begin
                     if (closed_ff && pos_ff < len_ff) begin
                        first_in = (pos_ff == '0);
                        last_in  = (pos_ff + CW'(1) == len_ff);
                        mode_in  = head.mode;
                        pos_in   = pos_ff + CW'(1);
                        state_in = S_RD_MEM;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_DIV_START: begin
            // zero peak keeps the current scale
            if (peak_ff == '0) begin
               state_in = S_IDLE;
            end else begin
               div_go   = 1'b1;
               state_in = S_DIV_WAIT;
            end
         end
         S_DIV_WAIT: begin
            if (div_done) begin
               if (div_q < scale_ff) begin
                  scale_in = div_q;
                  state_in = S_IDLE;
               end else begin
                  diff_in  = div_q - scale_ff;
                  state_in = S_ALPHA_HI;
               end
            end
         end
         S_ALPHA_HI: begin
            mul_a    = {1'b0, alpha_ff};
            mul_b    = diff_ff[SCALE_W-1:24];
            state_in = S_ALPHA_LO;
         end
         S_ALPHA_LO: begin
            mul_a    = {1'b0, alpha_ff};
            mul_b    = diff_ff[23:0];
            hi_in    = prod_ff;
            state_in = S_ALPHA_SUM;
         end
         S_ALPHA_SUM: begin
            step_in  = sum72[71:32];
            state_in = S_SCALE_ADD;
         end
         S_SCALE_ADD: begin
            scale_in = scale_ff + {8'd0, step_ff};
            state_in = S_IDLE;
         end
         S_RD_MEM: begin
            m_in     = m_now;
            neg_in   = rdata_ff[SAMPLE_W-1];
            mul_a    = m_now;
            mul_b    = scale_ff[SCALE_W-1:24];
            state_in = S_RD_MUL_LO;
         end
         S_RD_MUL_LO: begin
            mul_a    = m_ff;
            mul_b    = scale_ff[23:0];
            hi_in    = prod_ff;
            state_in = S_RD_SUM;
         end
         S_RD_SUM: begin
            big_in   = |hi_ff[SCALE_W-1:24];
            p_in     = {1'b0, hi_ff[23:0], 24'd0} + {1'b0, prod_ff};
            state_in = S_RD_LEVEL;
         end
         S_RD_LEVEL: begin
            sat_zero_in = 1'b0;
            sat_full_in = 1'b0;
            if (mode_ff == MODE_SPECTRUM) begin
               v_in = p_ff[SCALE_W-1:0];
               if (neg_ff) begin
                  sat_zero_in = 1'b1;
               end else if (big_ff || p_ge_one) begin
                  sat_full_in = 1'b1;
               end
            end else begin
               v_in = neg_ff ? ONE_Q47 - p_ff[SCALE_W-1:0] : ONE_Q47 + p_ff[SCALE_W-1:0];
               if (big_ff || p_ge_one) begin
                  sat_zero_in = neg_ff;
                  sat_full_in = !neg_ff;
               end
            end
            state_in = S_RD_OUT;
         end
         S_RD_OUT: begin
            if (first_ff) begin
               code_in = CODE_FIRST;
            end else if (sat_zero_ff) begin
               code_in = CODE_ZERO;
            end else if (sat_full_ff) begin
               code_in = CODE_MAX;
            end else if (mode_ff == MODE_SPECTRUM) begin
               code_in = t60[58:47];
            end else begin
               code_in = t60[59:48];
            end
            rlast_in  = last_ff;
            strobe_in = 1'b1;
            state_in  = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         len_ff    <= '0;
         pos_ff    <= '0;
         peak_ff   <= '0;
         scale_ff  <= '0;
         closed_ff <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         len_ff    <= len_in;
         pos_ff    <= pos_in;
         peak_ff   <= peak_in;
         scale_ff  <= scale_in;
         closed_ff <= closed_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      diff_ff     <= diff_in;
      alpha_ff    <= alpha_in;
      hi_ff       <= hi_in;
      prod_ff     <= mul_a * mul_b;
      step_ff     <= step_in;
      m_ff        <= m_in;
      neg_ff      <= neg_in;
      first_ff    <= first_in;
      last_ff     <= last_in;
      mode_ff     <= mode_in;
      big_ff      <= big_in;
      p_ff        <= p_in;
      v_ff        <= v_in;
      sat_zero_ff <= sat_zero_in;
      sat_full_ff <= sat_full_in;
      code_ff     <= code_in;
      rlast_ff    <= rlast_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         frame_mem[mem_waddr] <= head.sample;
      end
      rdata_ff <= frame_mem[mem_raddr];
   end

endmodule

/* hdl/peak_normalizing_dac_quantizer.sv */
// -----------------------------------------------------------------------------
// peak_normalizing_dac_quantizer
// Frame store with peak-tracking gain and 12-bit DAC code readout.
// -----------------------------------------------------------------------------
// Commands enter a four-deep queue whenever busy is low; busy rises only when
// that queue is full. The execution side takes one queued command at a time:
// a push that closes the frame adds the bit-serial 48-step reciprocal and the
// two-part smoothing multiply (the reciprocal is taken at once when it is
// below the current scale, and a zero peak keeps the scale), and a read
// passes through the frame memory's registered read port, then twice through
// the shared 24x24 multiplier, and through the code scaling stage. Each code
// appears on rsp_code for one cycle with rsp_strobe high and must be taken
// then; reads beyond the closed frame, or before a frame is closed, give no
// strobe. The mode register applies to commands accepted after it is written.
// -----------------------------------------------------------------------------
module peak_normalizing_dac_quantizer #(
   parameter int FRAME_DEPTH = 1024
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic                        req_cmd,
   input  logic signed [23:0]          req_sample,
   input  logic                        req_frame_end,
   output logic                        rsp_strobe,
   output logic [11:0]                 rsp_code,
   output logic                        rsp_last_code,
   input  logic                        csr_wr_en,
   input  logic                        csr_wr_data
);
   import pndq_pkg::*;

   item_type   head;
   logic       empty;
   logic       pop;

   pndq_front u_front (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_cmd       (req_cmd),
      .req_sample    (req_sample),
      .req_frame_end (req_frame_end),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .pop           (pop),
      .head          (head),
      .empty         (empty)
   );

   pndq_back #(
      .FRAME_DEPTH (FRAME_DEPTH)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .head          (head),
      .empty         (empty),
      .pop           (pop),
      .rsp_strobe    (rsp_strobe),
      .rsp_code      (rsp_code),
      .rsp_last_code (rsp_last_code)
   );

endmodule

/* hdl/pndq_checker.sv */
// -----------------------------------------------------------------------------
// pndq_checker
// Port-level checks on the quantizer's reset, busy flag and result spacing.
// -----------------------------------------------------------------------------
`include "assert_macros.svh"

module pndq_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic        rsp_strobe
);

   logic accept;

   assign accept = start && !busy;

   // reset empties the queue and drops any pending result
   `ASSERT_NEXT(a_reset_clear, clock, 1'b0, reset, !busy && !rsp_strobe)

   // each read passes through the read states in turn, so result strobes are spread out
   `ASSERT_NEXT(a_strobe_gap1, clock, reset, rsp_strobe, !rsp_strobe)
   `ASSERT_SAME(a_strobe_gap2, clock, reset, rsp_strobe, !$past(rsp_strobe, 2))

   // the queue can only fill through an accepted transaction
   `ASSERT_NEXT(a_busy_needs_fill, clock, reset, !busy && !accept, !busy)

endmodule

bind peak_normalizing_dac_quantizer pndq_checker u_pndq_checker (
   .clock         (clock),
   .reset         (reset),
   .start         (start),
   .busy          (busy),
   .rsp_strobe    (rsp_strobe)
);
